### sv/lcar_pkg.sv
package lcar_pkg;

    localparam int DATA_BITS        = 24;
    localparam int MAX_SAMPLES_LOG2 = 6;

    localparam int RAW_W      = 24;
    localparam int TARE_W     = 24;
    localparam int SCALE_W    = 32;
    localparam int DIFF_W     = RAW_W + 1;
    localparam int WEIGHT_W   = DIFF_W + SCALE_W;
    localparam int GAIN_W     = 2;
    localparam int SLOG2_W    = 3;
    localparam int HALF_W     = 8;

    localparam int BIT_W  = $clog2(DATA_BITS + 1);
    localparam int CNT_W  = MAX_SAMPLES_LOG2 + 1;
    localparam int SUM_W  = DATA_BITS + MAX_SAMPLES_LOG2 + 1;
    localparam int N_W    = (MAX_SAMPLES_LOG2 > 0) ? $clog2(MAX_SAMPLES_LOG2 + 1) : 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PULSES       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_OFFSET       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_LOG2      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD_TICKS = 3'd4;

endpackage

### sv/load_cell_adc_reader_top.sv
// Load cell converter readout. Each input beat is one tick of the converter
// interface: it carries the sampled data-out pin and an optional request to
// start a weighing, and every input beat yields exactly one result beat with
// the serial clock drive for that tick, the busy flag and, on the reporting
// tick, the averaged raw reading and the tared, scaled weight. One tick is
// taken per clock cycle unless m_ready stalls. A result passes the input
// register, the sequencing stage that updates the pin state and the running
// sum, the averaging stage that rounds the sum toward zero and subtracts the
// tare, and the 25 x 32 bit multiplier stage. Registers are written over the
// cfg port (index 0 gain pulses, 1 tare, 2 scale, 3 samples log2, 4 half
// period ticks) by the user only while no weighing runs; not enforced.
module load_cell_adc_reader_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lcar_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic                                s_dout_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_sck_level,
    output logic                                m_busy_res,
    output logic                                m_result_valid,
    output logic signed [lcar_pkg::RAW_W-1:0]   m_raw_average,
    output logic signed [lcar_pkg::WEIGHT_W-1:0] m_weight
);
    import lcar_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_SHIFT,
        PH_PULSE
    } phase_t;

    // configuration
    logic [GAIN_W-1:0]         gain_pulses_reg;
    logic signed [TARE_W-1:0]  tare_offset_reg;
    logic signed [SCALE_W-1:0] scale_factor_reg;
    logic [SLOG2_W-1:0]        samples_log2_reg;
    logic [HALF_W-1:0]         half_period_reg;

    // sequencer state
    phase_t                    phase_reg, phase_next;
    logic [BIT_W-1:0]          bit_count_reg, bit_count_next;
    logic [DATA_BITS-1:0]      shift_word_reg, shift_word_next;
    logic [CNT_W-1:0]          sample_count_reg, sample_count_next;
    logic signed [SUM_W-1:0]   sample_sum_reg, sample_sum_next;
    logic [HALF_W-1:0]         half_timer_reg, half_timer_next;
    logic                      clock_out_reg, clock_out_next;

    // pipeline
    logic                      in_vld_reg;
    logic                      in_req_reg, in_dout_reg;
    logic                      p1_vld_reg;
    logic                      p1_sck_reg, p1_busy_reg, p1_rv_reg;
    logic signed [SUM_W-1:0]   p1_sum_reg, p1_sum_next;
    logic [N_W-1:0]            p1_n_reg;
    logic                      p1_rv_next;
    logic                      p2_vld_reg;
    logic                      p2_sck_reg, p2_busy_reg, p2_rv_reg;
    logic signed [RAW_W-1:0]   p2_raw_reg;
    logic signed [DIFF_W-1:0]  p2_diff_reg;
    logic                      out_vld_reg;
    logic                      out_sck_reg, out_busy_reg, out_rv_reg;
    logic signed [RAW_W-1:0]   out_raw_reg;
    logic signed [WEIGHT_W-1:0] out_weight_reg;

    logic out_can, p2_can, p1_can, in_can;
    logic in_fire, p1_fire, p2_fire, out_fire;

    assign out_can  = !out_vld_reg || m_ready;
    assign p2_can   = !p2_vld_reg || out_can;
    assign p1_can   = !p1_vld_reg || p2_can;
    assign in_can   = !in_vld_reg || p1_can;
    assign in_fire  = s_valid && in_can;
    assign p1_fire  = in_vld_reg && p1_can;
    assign p2_fire  = p1_vld_reg && p2_can;
    assign out_fire = p2_vld_reg && out_can;

    assign s_ready   = in_can;
    assign cfg_ready = 1'b1;

    // sequencing
    logic [N_W-1:0]         n_eff;
    logic [HALF_W-1:0]      hp_eff;
    logic [GAIN_W-1:0]      gp_eff;
    logic [BIT_W-1:0]       bit_inc;
    logic [CNT_W-1:0]       cnt_inc;
    logic [CNT_W-1:0]       cnt_target;
    logic signed [SUM_W-1:0] sum_acc;

    assign n_eff  = (32'(samples_log2_reg) > MAX_SAMPLES_LOG2)
                    ? N_W'(MAX_SAMPLES_LOG2) : N_W'(samples_log2_reg);
    assign hp_eff = (half_period_reg == '0) ? HALF_W'(1) : half_period_reg;
    assign gp_eff = (gain_pulses_reg == '0) ? GAIN_W'(1) : gain_pulses_reg;
    assign bit_inc    = bit_count_reg + BIT_W'(1);
    assign cnt_inc    = sample_count_reg + CNT_W'(1);
    assign cnt_target = CNT_W'(1) << n_eff;
    assign sum_acc    = sample_sum_reg + SUM_W'($signed(shift_word_reg));

    always_comb begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        shift_word_next   = shift_word_reg;
        sample_count_next = sample_count_reg;
        sample_sum_next   = sample_sum_reg;
        half_timer_next   = half_timer_reg;
        clock_out_next    = clock_out_reg;
        p1_rv_next        = 1'b0;
        p1_sum_next       = '0;
        unique case (phase_reg)
            PH_IDLE: begin
                clock_out_next = 1'b1;
                if (in_req_reg) begin
                    clock_out_next    = 1'b0;
                    phase_next        = PH_WAIT;
                    sample_count_next = '0;
                    sample_sum_next   = '0;
                end
            end
            PH_WAIT: begin
                clock_out_next = 1'b0;
                if (!in_dout_reg) begin
                    phase_next      = PH_SHIFT;
                    bit_count_next  = '0;
                    half_timer_next = '0;
                    shift_word_next = '0;
                end
            end
            PH_SHIFT, PH_PULSE: begin
                if (half_timer_reg < hp_eff - HALF_W'(1)) begin
                    half_timer_next = half_timer_reg + HALF_W'(1);
                end else begin
                    half_timer_next = '0;
                    if (!clock_out_reg) begin
                        clock_out_next = 1'b1;
                    end else begin
                        clock_out_next = 1'b0;
                        if (phase_reg == PH_SHIFT) begin
                            shift_word_next = {shift_word_reg[DATA_BITS-2:0], in_dout_reg};
                            bit_count_next  = bit_inc;
                            if (32'(bit_inc) >= DATA_BITS) begin
                                phase_next     = PH_PULSE;
                                bit_count_next = '0;
                            end
                        end else begin
                            bit_count_next = bit_inc;
                            if (bit_inc >= BIT_W'(gp_eff)) begin
                                bit_count_next = '0;
                                if (cnt_inc >= cnt_target) begin
                                    p1_rv_next        = 1'b1;
                                    p1_sum_next       = sum_acc;
                                    phase_next        = PH_IDLE;
                                    clock_out_next    = 1'b1;
                                    sample_count_next = '0;
                                    sample_sum_next   = '0;
                                end else begin
                                    phase_next        = PH_WAIT;
                                    sample_count_next = cnt_inc;
                                    sample_sum_next   = sum_acc;
                                end
                            end
                        end
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // averaging: divide by 2^n rounding toward zero, then tare
    logic [SUM_W-1:0]        round_bias;
    logic signed [SUM_W-1:0] avg_full;
    logic signed [RAW_W-1:0] raw_c;
    logic signed [DIFF_W-1:0] diff_c;

    assign round_bias = p1_sum_reg[SUM_W-1] ? ~({SUM_W{1'b1}} << p1_n_reg) : '0;
    assign avg_full   = (p1_sum_reg + $signed(round_bias)) >>> p1_n_reg;
    assign raw_c      = p1_rv_reg ? RAW_W'($signed(avg_full[DATA_BITS-1:0])) : '0;
    assign diff_c     = p1_rv_reg ? (DIFF_W'(raw_c) - DIFF_W'(tare_offset_reg)) : '0;

    logic signed [WEIGHT_W-1:0] weight_c;
    assign weight_c = WEIGHT_W'(p2_diff_reg) * WEIGHT_W'(scale_factor_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_pulses_reg  <= GAIN_W'(1);
            tare_offset_reg  <= '0;
            scale_factor_reg <= SCALE_W'(32'h0100_0000);
            samples_log2_reg <= SLOG2_W'(3);
            half_period_reg  <= HALF_W'(1);
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= '0;
            shift_word_reg   <= '0;
            sample_count_reg <= '0;
            sample_sum_reg   <= '0;
            half_timer_reg   <= '0;
            clock_out_reg    <= 1'b1;
            in_vld_reg       <= 1'b0;
            p1_vld_reg       <= 1'b0;
            p2_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_GAIN_PULSES:       gain_pulses_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_TARE_OFFSET:       tare_offset_reg  <= cfg_data[TARE_W-1:0];
                    CFG_SCALE_FACTOR:      scale_factor_reg <= cfg_data[SCALE_W-1:0];
                    CFG_SAMPLES_LOG2:      samples_log2_reg <= cfg_data[SLOG2_W-1:0];
                    CFG_HALF_PERIOD_TICKS: half_period_reg  <= cfg_data[HALF_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (in_can) begin
                in_vld_reg <= s_valid;
            end
            if (p1_fire) begin
                phase_reg        <= phase_next;
                bit_count_reg    <= bit_count_next;
                shift_word_reg   <= shift_word_next;
                sample_count_reg <= sample_count_next;
                sample_sum_reg   <= sample_sum_next;
                half_timer_reg   <= half_timer_next;
                clock_out_reg    <= clock_out_next;
            end
            if (p1_can) begin
                p1_vld_reg <= in_vld_reg;
            end
            if (p2_can) begin
                p2_vld_reg <= p1_vld_reg;
            end
            if (out_can) begin
                out_vld_reg <= p2_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_req_reg  <= s_req_type;
            in_dout_reg <= s_dout_level;
        end
        if (p1_fire) begin
            p1_sck_reg  <= clock_out_next;
            p1_busy_reg <= (phase_next != PH_IDLE);
            p1_rv_reg   <= p1_rv_next;
            p1_sum_reg  <= p1_sum_next;
            p1_n_reg    <= n_eff;
        end
        if (p2_fire) begin
            p2_sck_reg  <= p1_sck_reg;
            p2_busy_reg <= p1_busy_reg;
            p2_rv_reg   <= p1_rv_reg;
            p2_raw_reg  <= raw_c;
            p2_diff_reg <= diff_c;
        end
        if (out_fire) begin
            out_sck_reg    <= p2_sck_reg;
            out_busy_reg   <= p2_busy_reg;
            out_rv_reg     <= p2_rv_reg;
            out_raw_reg    <= p2_raw_reg;
            out_weight_reg <= weight_c;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_sck_level    = out_sck_reg;
    assign m_busy_res     = out_busy_reg;
    assign m_result_valid = out_rv_reg;
    assign m_raw_average  = out_raw_reg;
    assign m_weight       = out_weight_reg;

    a_idle_powered_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> clock_out_reg)
        else $error("converter clock low while idle");

    a_report_ends_weighing: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_valid) |-> (!m_busy_res && m_sck_level))
        else $error("report beat while still busy or clock low");

    a_no_report_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_result_valid) |-> (m_weight == '0 && m_raw_average == '0))
        else $error("non-report beat carries a reading");

    a_bit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SHIFT) |-> (32'(bit_count_reg) < DATA_BITS))
        else $error("data bit count overran");

endmodule

### tb/sv/tb.sv
module tb;
    import lcar_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int RAND_TICKS     = 300;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_SHIFT,
        ST_PULSE
    } seq_state_t;

    typedef enum logic {
        SRC_NOISE,
        SRC_WORDS
    } src_mode_t;

    typedef struct {
        logic                sck;
        logic                busy;
        logic                done;
        logic [RAW_W-1:0]    raw;
        logic [WEIGHT_W-1:0] weight;
    } tick_result_t;

    class weigh_scoreboard;
        logic [GAIN_W-1:0]    r_gain;
        logic [TARE_W-1:0]    r_tare;
        logic [SCALE_W-1:0]   r_scale;
        logic [SLOG2_W-1:0]   r_avg_log2;
        logic [HALF_W-1:0]    r_half;

        seq_state_t           seq_state;
        int                   bits_in;
        logic [DATA_BITS-1:0] data_word;
        int                   readings;
        longint               reading_sum;
        int                   tick_cnt;
        logic                 sck_drive;

        tick_result_t         pending[$];
        int                   errors;
        int                   ticks_seen;
        int                   weighings_begun;

        function new();
            r_gain          = 2'd1;
            r_tare          = '0;
            r_scale         = 32'h0100_0000;
            r_avg_log2      = 3'd3;
            r_half          = 8'd1;
            seq_state       = ST_IDLE;
            bits_in         = 0;
            data_word       = '0;
            readings        = 0;
            reading_sum     = 0;
            tick_cnt        = 0;
            sck_drive       = 1'b1;
            errors          = 0;
            ticks_seen      = 0;
            weighings_begun = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GAIN_PULSES:       r_gain = data[GAIN_W-1:0];
                CFG_TARE_OFFSET:       r_tare = data[TARE_W-1:0];
                CFG_SCALE_FACTOR:      r_scale = data[SCALE_W-1:0];
                CFG_SAMPLES_LOG2:      r_avg_log2 = data[SLOG2_W-1:0];
                CFG_HALF_PERIOD_TICKS: r_half = data[HALF_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_tick(logic req, logic dout);
            tick_result_t r;
            logic         done;
            longint       avg;
            longint       wgt;
            int           hp;
            int           gp;
            int           n;
            int           t;
            done = 1'b0;
            avg  = 0;
            wgt  = 0;
            ticks_seen++;
            case (seq_state)
                ST_IDLE: begin
                    sck_drive = 1'b1;
                    if (req) begin
                        sck_drive   = 1'b0;
                        seq_state   = ST_WAIT;
                        readings    = 0;
                        reading_sum = 0;
                        weighings_begun++;
                    end
                end
                ST_WAIT: begin
                    sck_drive = 1'b0;
                    if (!dout) begin
                        seq_state = ST_SHIFT;
                        bits_in   = 0;
                        tick_cnt  = 0;
                        data_word = '0;
                    end
                end
                default: begin
                    hp = (r_half == 0) ? 1 : int'(r_half);
                    t  = tick_cnt + 1;
                    if (t < hp) begin
                        tick_cnt = t;
                    end else begin
                        tick_cnt = 0;
                        if (!sck_drive) begin
                            sck_drive = 1'b1;
                        end else begin
                            sck_drive = 1'b0;
                            if (seq_state == ST_SHIFT) begin
                                data_word = {data_word[DATA_BITS-2:0], dout};
                                bits_in++;
                                if (bits_in >= DATA_BITS) begin
                                    seq_state = ST_PULSE;
                                    bits_in   = 0;
                                end
                            end else begin
                                gp = (r_gain == 0) ? 1 : int'(r_gain);
                                bits_in++;
                                if (bits_in >= gp) begin
                                    n = (r_avg_log2 > MAX_SAMPLES_LOG2) ? MAX_SAMPLES_LOG2
                                                                        : int'(r_avg_log2);
                                    bits_in = 0;
                                    reading_sum += longint'($signed(data_word));
                                    readings++;
                                    if (readings >= (1 << n)) begin
                                        avg = reading_sum / (longint'(1) << n);
                                        wgt = (avg - longint'($signed(r_tare)))
                                              * longint'($signed(r_scale));
                                        done        = 1'b1;
                                        seq_state   = ST_IDLE;
                                        sck_drive   = 1'b1;
                                        readings    = 0;
                                        reading_sum = 0;
                                    end else begin
                                        seq_state = ST_WAIT;
                                    end
                                end
                            end
                        end
                    end
                end
            endcase
            r.sck    = sck_drive;
            r.busy   = (seq_state != ST_IDLE);
            r.done   = done;
            r.raw    = avg[RAW_W-1:0];
            r.weight = wgt[WEIGHT_W-1:0];
            pending.push_back(r);
        endfunction

        function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] got);
            if (got !== exp_v) begin
                $error("%s: expected %h, actual %h", name, exp_v, got);
                errors++;
            end
        endfunction

        function void check_beat(logic sck, logic busy, logic done, logic [RAW_W-1:0] raw,
                                 logic [WEIGHT_W-1:0] weight);
            tick_result_t e;
            if (pending.size() == 0) begin
                $error("result beat with no tick waiting for it");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp_field("sck_level", e.sck, sck);
            cmp_field("busy_res", e.busy, busy);
            cmp_field("result_valid", e.done, done);
            cmp_field("raw_average", e.raw, raw);
            cmp_field("weight", e.weight, weight);
        endfunction
    endclass

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic                         s_req_type = 1'b0;
    logic                         s_dout_level = 1'b1;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic                         m_sck_level;
    logic                         m_busy_res;
    logic                         m_result_valid;
    logic signed [RAW_W-1:0]      m_raw_average;
    logic signed [WEIGHT_W-1:0]   m_weight;

    weigh_scoreboard sb;
    bit              hold_off_req = 0;

    load_cell_adc_reader_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_dout_level   (s_dout_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sck_level    (m_sck_level),
        .m_busy_res     (m_busy_res),
        .m_result_valid (m_result_valid),
        .m_raw_average  (m_raw_average),
        .m_weight       (m_weight)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [DATA_BITS-1:0] pick_word();
        logic [DATA_BITS-1:0] w;
        case ($urandom_range(0, 7))
            0: w = '0;
            1: w = '1;
            2: w = {1'b0, {(DATA_BITS-1){1'b1}}};
            3: w = {1'b1, {(DATA_BITS-1){1'b0}}};
            default: w = DATA_BITS'($urandom());
        endcase
        return w;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        sb.write_reg(idx, data);
    endtask

    // unused upper bits of each write carry junk
    task automatic program_regs(logic [GAIN_W-1:0] gain, logic [TARE_W-1:0] tare,
                                logic [SCALE_W-1:0] scale, logic [SLOG2_W-1:0] slog2,
                                logic [HALF_W-1:0] half, bit poke_unused);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom();
        if (poke_unused)
            write_reg(CFG_NO_REG, $urandom());
        write_reg(CFG_GAIN_PULSES, {junk[CFG_DATA_W-1:GAIN_W], gain});
        write_reg(CFG_TARE_OFFSET, {junk[CFG_DATA_W-1:TARE_W], tare});
        write_reg(CFG_SCALE_FACTOR, scale);
        write_reg(CFG_SAMPLES_LOG2, {junk[CFG_DATA_W-1:SLOG2_W], slog2});
        write_reg(CFG_HALF_PERIOD_TICKS, {junk[CFG_DATA_W-1:HALF_W], half});
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic drive_phase(int n_weigh, src_mode_t mode, bit use_fixed,
                               logic [DATA_BITS-1:0] fixed_word, bit no_gaps);
        int                   begun_at;
        int                   burst_left;
        int                   gap_left;
        bit                   fin;
        logic                 req;
        logic                 dout;
        logic [DATA_BITS-1:0] cur_word;
        begun_at   = sb.weighings_begun;
        burst_left = $urandom_range(1, 40);
        gap_left   = 0;
        fin        = 0;
        cur_word   = fixed_word;
        while (!fin) begin
            @(posedge aclk);
            if (s_valid && s_ready) begin
                sb.note_tick(s_req_type, s_dout_level);
            end else if (s_valid) begin
                continue;
            end
            if (sb.weighings_begun - begun_at >= n_weigh && sb.seq_state == ST_IDLE) begin
                s_valid <= 1'b0;
                fin = 1;
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else begin
                if (sb.seq_state == ST_IDLE)
                    req = (sb.weighings_begun - begun_at < n_weigh) && ($urandom_range(0, 2) == 0);
                else
                    req = ($urandom_range(0, 3) == 0);
                dout = 1'($urandom_range(0, 1));
                if (mode == SRC_WORDS) begin
                    if (sb.seq_state == ST_WAIT)
                        cur_word = use_fixed ? fixed_word : pick_word();
                    else if (sb.seq_state == ST_SHIFT)
                        dout = cur_word[DATA_BITS-1-sb.bits_in];
                end
                s_valid      <= 1'b1;
                s_req_type   <= req;
                s_dout_level <= dout;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = (no_gaps || $urandom_range(0, 3) == 0) ? 0
                                                                        : $urandom_range(1, 6);
                end
            end
        end
    endtask

    task automatic random_phase(bit press);
        logic [GAIN_W-1:0]  gain;
        logic [TARE_W-1:0]  tare;
        logic [SCALE_W-1:0] scale;
        logic [SLOG2_W-1:0] slog2;
        logic [HALF_W-1:0]  half;
        int                 n_weigh;
        src_mode_t          mode;
        gain = GAIN_W'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0: tare = {1'b1, {(TARE_W-1){1'b0}}};
            1: tare = {1'b0, {(TARE_W-1){1'b1}}};
            2: tare = '0;
            default: tare = TARE_W'($urandom());
        endcase
        case ($urandom_range(0, 5))
            0: scale = 32'h8000_0000;
            1: scale = 32'h7FFF_FFFF;
            2: scale = 32'h0100_0000;
            default: scale = $urandom();
        endcase
        half    = HALF_W'($urandom_range(0, 2));
        slog2   = SLOG2_W'($urandom_range(0, 2));
        n_weigh = (slog2 >= 2) ? 1 : $urandom_range(1, 2);
        mode    = ($urandom_range(0, 3) == 0) ? SRC_NOISE : SRC_WORDS;
        program_regs(gain, tare, scale, slog2, half, $urandom_range(0, 3) == 0);
        if (press)
            hold_off_req = 1;
        drive_phase(n_weigh, mode, 0, '0, press || $urandom_range(0, 4) == 0);
        settle();
    endtask

    initial begin
        int run_left;
        int hold_left;
        bit stall;
        run_left  = 0;
        hold_left = 0;
        stall     = 1;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 0;
                hold_left    = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    stall    = !stall;
                    run_left = stall ? $urandom_range(1, 6) : $urandom_range(1, 40);
                    if (!stall && $urandom_range(0, 7) == 0)
                        run_left = 300;
                end
                run_left--;
                m_ready <= !stall;
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_beat(m_sck_level, m_busy_res, m_result_valid, m_raw_average, m_weight);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int  tick_base;
        int  waited;
        bit  first;
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        drive_phase(1, SRC_WORDS, 1, 24'h7F_FFFF, 0);
        settle();
        program_regs(2'd0, 24'h80_0000, 32'h7FFF_FFFF, 3'd0, 8'd0, 1);
        drive_phase(1, SRC_WORDS, 1, 24'h7F_FFFF, 0);
        settle();
        program_regs(2'd1, 24'h7F_FFFF, 32'h8000_0000, 3'd0, 8'd1, 0);
        drive_phase(1, SRC_WORDS, 1, 24'h80_0000, 0);
        settle();
        program_regs(2'd3, 24'h00_0000, 32'h0100_0000, 3'd1, 8'd1, 0);
        drive_phase(1, SRC_WORDS, 1, 24'hFF_FFFF, 1);
        settle();
        program_regs(2'd2, TARE_W'($urandom()), $urandom(), 3'd0, 8'd3, 0);
        drive_phase(1, SRC_WORDS, 0, '0, 0);
        settle();

        tick_base = sb.ticks_seen;
        first     = 1;
        while (sb.ticks_seen - tick_base < RAND_TICKS) begin
            random_phase(first);
            first = 0;
        end

        waited = 0;
        while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        if (sb.pending.size() != 0) begin
            $error("%0d expected result beats never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### load_cell_adc_reader_top.f
sv/lcar_pkg.sv
sv/load_cell_adc_reader_top.sv
tb/sv/tb.sv
